### hdl/dbcs_pkg.sv
// ----------------------------------------------------------------------------
// dbcs_pkg
// Shared types, constants and helpers for the DEFLATE block cost selector.
// ----------------------------------------------------------------------------
package dbcs_pkg;

  localparam int unsigned SumW     = 32;
  localparam int unsigned SlotW    = 9;
  localparam int unsigned CountW   = 16;
  localparam int unsigned ClenW    = 4;
  localparam int unsigned HdrW     = 12;
  localparam int unsigned KindW    = 2;
  localparam int unsigned LenW     = 4;   // fixed length and extra bits
  localparam int unsigned CostLenW = LenW + 1;
  localparam int unsigned ProdW    = CountW + CostLenW;

  localparam logic [SumW-1:0] SatVal     = '1;
  localparam logic [HdrW:0]   HdrAdjust  = 13'd3;

  typedef enum logic [KindW-1:0] {
    KIND_DYNAMIC = 2'd0,
    KIND_FIXED   = 2'd1,
    KIND_RAW     = 2'd2
  } kind_e;

  typedef struct packed {
    logic            used;
    logic [LenW-1:0] base_len;
    logic [LenW-1:0] extra;
  } slot_cost_t;

  // Fixed code length and extra bits per RFC 1951 for one histogram slot.
  function automatic slot_cost_t slot_cost_f(logic [SlotW-1:0] slot);
    slot_cost_t      c;
    logic [SlotW-1:0] d;
    c = '0;
    d = slot - 9'd288;
    if (slot <= 9'd285) begin
      c.used = 1'b1;
      if (slot <= 9'd143) begin
        c.base_len = 4'd8;
      end else if (slot <= 9'd255) begin
        c.base_len = 4'd9;
      end else if (slot <= 9'd279) begin
        c.base_len = 4'd7;
      end else begin
        c.base_len = 4'd8;
      end
      if (slot >= 9'd265 && slot <= 9'd284) begin
        c.extra = LenW'((slot - 9'd261) >> 2);
      end
    end else if (slot >= 9'd288 && slot <= 9'd317) begin
      c.used     = 1'b1;
      c.base_len = 4'd5;
      if (d >= 9'd4) begin
        c.extra = LenW'((d - 9'd2) >> 1);
      end
    end
    return c;
  endfunction

  // Saturating add; a saturated sum stays saturated.
  function automatic logic [SumW-1:0] sat_add_f(logic [SumW-1:0] a,
                                                 logic [ProdW-1:0] b);
    logic [SumW:0] t;
    t = {1'b0, a} + (SumW+1)'(b);
    if (a == SatVal || t >= {1'b0, SatVal}) begin
      return SatVal;
    end
    return t[SumW-1:0];
  endfunction

endpackage

### hdl/dbcs_accum.sv
// ----------------------------------------------------------------------------
// dbcs_accum
// Per-entry cost decode and saturating dynamic/fixed bit accumulators.
// ----------------------------------------------------------------------------
module dbcs_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          clr_i,
  input  logic [dbcs_pkg::SlotW-1:0]    sym_slot_i,
  input  logic [dbcs_pkg::CountW-1:0]   sym_count_i,
  input  logic [dbcs_pkg::ClenW-1:0]    code_len_i,
  output logic [dbcs_pkg::SumW-1:0]     dyn_sum_o,
  output logic [dbcs_pkg::SumW-1:0]     fix_sum_o
);
  import dbcs_pkg::*;

  slot_cost_t          cost;
  logic [CostLenW-1:0] dyn_len;
  logic [CostLenW-1:0] fix_len;
  logic [ProdW-1:0]    dyn_prod;
  logic [ProdW-1:0]    fix_prod;
  logic [SumW-1:0]     dyn_sum_q, dyn_sum_d;
  logic [SumW-1:0]     fix_sum_q, fix_sum_d;

  always_comb begin
    cost     = slot_cost_f(sym_slot_i);
    dyn_len  = CostLenW'(code_len_i) + CostLenW'(cost.extra);
    fix_len  = CostLenW'(cost.base_len) + CostLenW'(cost.extra);
    dyn_prod = ProdW'(sym_count_i) * ProdW'(dyn_len);
    fix_prod = ProdW'(sym_count_i) * ProdW'(fix_len);
    if (!cost.used) begin
      dyn_prod = '0;
      fix_prod = '0;
    end
    dyn_sum_d = sat_add_f(dyn_sum_q, dyn_prod);
    fix_sum_d = sat_add_f(fix_sum_q, fix_prod);
  end

  // Sums including the current entry.
  assign dyn_sum_o = dyn_sum_d;
  assign fix_sum_o = fix_sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_sum_q <= '0;
      fix_sum_q <= '0;
    end else if (en_i) begin
      dyn_sum_q <= clr_i ? '0 : dyn_sum_d;
      fix_sum_q <= clr_i ? '0 : fix_sum_d;
    end
  end

endmodule

### hdl/dbcs_choose.sv
// ----------------------------------------------------------------------------
// dbcs_choose
// Header correction of the dynamic cost and choice of the block kind.
// ----------------------------------------------------------------------------
module dbcs_choose (
  input  logic [dbcs_pkg::SumW-1:0]  dyn_sum_i,
  input  logic [dbcs_pkg::SumW-1:0]  fix_sum_i,
  input  logic [dbcs_pkg::HdrW-1:0]  header_bits_i,
  input  logic [dbcs_pkg::SumW-1:0]  raw_bits_i,
  output logic [dbcs_pkg::SumW-1:0]  dynamic_bits_o,
  output dbcs_pkg::kind_e            block_kind_o
);
  import dbcs_pkg::*;

  logic [SumW:0] hdr_sum;
  logic [SumW:0] hdr_adj;

  always_comb begin
    hdr_sum = {1'b0, dyn_sum_i} + (SumW+1)'(header_bits_i);
    hdr_adj = hdr_sum - (SumW+1)'(HdrAdjust);
    if (dyn_sum_i == SatVal) begin
      dynamic_bits_o = SatVal;
    end else if (hdr_sum < (SumW+1)'(HdrAdjust)) begin
      dynamic_bits_o = '0;
    end else if (hdr_adj >= {1'b0, SatVal}) begin
      dynamic_bits_o = SatVal;
    end else begin
      dynamic_bits_o = hdr_adj[SumW-1:0];
    end

    // Ties fall to the later choice.
    if (dynamic_bits_o < fix_sum_i && dynamic_bits_o < raw_bits_i) begin
      block_kind_o = KIND_DYNAMIC;
    end else if (fix_sum_i < raw_bits_i) begin
      block_kind_o = KIND_FIXED;
    end else begin
      block_kind_o = KIND_RAW;
    end
  end

endmodule

### hdl/deflate_block_cost_select.sv
// ----------------------------------------------------------------------------
// deflate_block_cost_select
// DEFLATE block cost estimator: dynamic vs fixed vs stored block choice.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one histogram entry per
//   transaction: slot, count, dynamic code length, last flag, and on the
//   last entry the dynamic header length and the stored-block size.
//   Output channel (out_valid_o / out_stall_i): one transaction per block,
//   carrying the dynamic cost, the fixed cost and the chosen block kind.
// Throughput: one entry per cycle unless a last entry is held (see Stall);
//   the decode, 16x5 multiply and saturating add that feed the two
//   accumulators are combinational.
// Path: the result of a block goes from the input register through the
//   final-sum register to the output register.
// Stall: non-last entries keep streaming into the accumulators while a
//   result waits in the output register; a last entry is held only when
//   the final-sum and output registers are both occupied and stalled.
// Reset: asynchronous, active low; empties all stages and clears both
//   accumulators to zero.
// ----------------------------------------------------------------------------
module deflate_block_cost_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // entry channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dbcs_pkg::SlotW-1:0]    sym_slot_i,
  input  logic [dbcs_pkg::CountW-1:0]   sym_count_i,
  input  logic [dbcs_pkg::ClenW-1:0]    code_len_i,
  input  logic                          last_slot_i,
  input  logic [dbcs_pkg::HdrW-1:0]     header_bits_i,
  input  logic [dbcs_pkg::SumW-1:0]     raw_bits_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dbcs_pkg::SumW-1:0]     dynamic_bits_o,
  output logic [dbcs_pkg::SumW-1:0]     fixed_bits_o,
  output logic [dbcs_pkg::KindW-1:0]    block_kind_o
);
  import dbcs_pkg::*;

  // Stage A: input register
  logic               a_vld_q;
  logic [SlotW-1:0]   a_slot_q;
  logic [CountW-1:0]  a_count_q;
  logic [ClenW-1:0]   a_clen_q;
  logic               a_last_q;
  logic [HdrW-1:0]    a_hdr_q;
  logic [SumW-1:0]    a_raw_q;

  // Stage B: final sums of a block
  logic               b_vld_q;
  logic [SumW-1:0]    b_dyn_q;
  logic [SumW-1:0]    b_fix_q;
  logic [HdrW-1:0]    b_hdr_q;
  logic [SumW-1:0]    b_raw_q;

  // Stage C: output register
  logic               c_vld_q;
  logic [SumW-1:0]    c_dyn_q;
  logic [SumW-1:0]    c_fix_q;
  kind_e              c_kind_q;

  logic               c_free;
  logic               b_free;
  logic               b_go;
  logic               a_go;
  logic               a_free;
  logic               in_take;
  logic [SumW-1:0]    dyn_sum;
  logic [SumW-1:0]    fix_sum;
  logic [SumW-1:0]    dyn_bits;
  kind_e              kind;

  // Flow control: only a last entry needs room downstream.
  assign c_free  = !c_vld_q || !out_stall_i;
  assign b_go    = b_vld_q && c_free;
  assign b_free  = !b_vld_q || c_free;
  assign a_go    = a_vld_q && (!a_last_q || b_free);
  assign a_free  = !a_vld_q || a_go;
  assign in_take = in_valid_i && a_free;

  assign in_stall_o = !a_free;

  dbcs_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (a_go),
    .clr_i       (a_last_q),
    .sym_slot_i  (a_slot_q),
    .sym_count_i (a_count_q),
    .code_len_i  (a_clen_q),
    .dyn_sum_o   (dyn_sum),
    .fix_sum_o   (fix_sum)
  );

  dbcs_choose u_choose (
    .dyn_sum_i      (b_dyn_q),
    .fix_sum_i      (b_fix_q),
    .header_bits_i  (b_hdr_q),
    .raw_bits_i     (b_raw_q),
    .dynamic_bits_o (dyn_bits),
    .block_kind_o   (kind)
  );

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_vld_q <= in_valid_i;
      end
      if (b_free) begin
        b_vld_q <= a_go && a_last_q;
      end
      if (c_free) begin
        c_vld_q <= b_go;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_slot_q  <= sym_slot_i;
      a_count_q <= sym_count_i;
      a_clen_q  <= code_len_i;
      a_last_q  <= last_slot_i;
      a_hdr_q   <= header_bits_i;
      a_raw_q   <= raw_bits_i;
    end
    if (a_go && a_last_q) begin
      b_dyn_q <= dyn_sum;
      b_fix_q <= fix_sum;
      b_hdr_q <= a_hdr_q;
      b_raw_q <= a_raw_q;
    end
    if (b_go) begin
      c_dyn_q  <= dyn_bits;
      c_fix_q  <= b_fix_q;
      c_kind_q <= kind;
    end
  end

  assign out_valid_o    = c_vld_q;
  assign dynamic_bits_o = c_dyn_q;
  assign fixed_bits_o   = c_fix_q;
  assign block_kind_o   = c_kind_q;

endmodule
